// File: src/aes_block_cipher_engine_macros.svh
// Assertion macros shared by the cipher engine modules.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef AES_BLOCK_CIPHER_ENGINE_MACROS_SVH
`define AES_BLOCK_CIPHER_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AES_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AES_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/aes_pkg.sv
package aes_pkg;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;
    localparam logic [1:0] KS_RSVD = 2'd3;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_0_7 = 3'd1;
    localparam logic [2:0] REG_KEY_8_15 = 3'd2;
    localparam logic [2:0] REG_KEY_16_23 = 3'd3;
    localparam logic [2:0] REG_KEY_24_31 = 3'd4;

    typedef enum logic {
        CORE_IDLE,
        CORE_RUN
    } t_core_state;

    localparam logic [2047:0] FWD_TAB = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_TAB = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return FWD_TAB[(11'd255 - {3'd0, b}) * 11'd8 +: 8];
    endfunction

    function automatic logic [7:0] rsbox(input logic [7:0] b);
        return INV_TAB[(11'd255 - {3'd0, b}) * 11'd8 +: 8];
    endfunction

    // Multiply by x in GF(2^8) modulo the AES polynomial.
    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // One column of MixColumns or InvMixColumns, first byte in the top bits.
    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m1 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m0 [4];
        logic [31:0] res;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            a[k]  = c[31 - 8 * k -: 8];
            x2[k] = xt(a[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
            if (inv) begin
                m0[k] = x8[k] ^ x4[k] ^ x2[k];
                m1[k] = x8[k] ^ x2[k] ^ a[k];
                m2[k] = x8[k] ^ x4[k] ^ a[k];
                m3[k] = x8[k] ^ a[k];
            end else begin
                m0[k] = x2[k];
                m1[k] = x2[k] ^ a[k];
                m2[k] = a[k];
                m3[k] = a[k];
            end
        end
        for (int r = 0; r < 4; r++) begin
            res[31 - 8 * r -: 8] = m0[r] ^ m1[(r + 1) % 4] ^ m2[(r + 2) % 4]
                                 ^ m3[(r + 3) % 4];
        end
        return res;
    endfunction

endpackage

// File: src/aes_kx_cell.sv
module aes_kx_cell
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_d,
    output logic [31:0] o_q
);

    logic [31:0] r_word;

    // One schedule word; it moves one place down the chain per step.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

// File: src/aes_key_sched.sv
`include "aes_block_cipher_engine_macros.svh"

module aes_key_sched
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [1:0]   i_key_size,
    input  logic [255:0] i_key,
    input  logic [3:0]   i_rd_addr,
    output logic [127:0] o_rd_key,
    output logic         o_busy
);

    logic         r_busy;
    logic [5:0]   r_idx;
    logic [2:0]   r_j;
    logic [7:0]   r_rc;
    logic [127:0] r_rd;
    logic [127:0] mem [15];

    logic [3:0]  nk;
    logic [5:0]  total;
    logic [2:0]  far_sel;
    logic        is_key;
    logic [31:0] key_word;
    logic [31:0] prev;
    logic [31:0] tmp;
    logic [31:0] new_word;
    logic [31:0] cell_q  [8];
    logic [31:0] chain_in [8];

    always_comb begin
        unique case (i_key_size)
            KS_128:  nk = 4'd4;
            KS_192:  nk = 4'd6;
            default: nk = 4'd8;
        endcase
    end

    assign total    = {nk, 2'b00} + 6'd28;
    assign far_sel  = 3'(nk - 4'd1);
    assign is_key   = r_idx < {2'b00, nk};
    assign key_word = i_key[(3'd7 - r_idx[2:0]) * 8'd32 +: 32];
    assign prev     = cell_q[0];

    always_comb begin
        if (r_j == 3'd0) begin
            tmp = sub_word({prev[23:0], prev[31:24]}) ^ {r_rc, 24'd0};
        end else if (nk == 4'd8 && r_j == 3'd4) begin
            tmp = sub_word(prev);
        end else begin
            tmp = prev;
        end
        new_word = is_key ? key_word : (cell_q[far_sel] ^ tmp);
    end

    for (genvar g = 0; g < 8; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign chain_in[g] = new_word;
        end else begin : g_body
            assign chain_in[g] = cell_q[g - 1];
        end
        aes_kx_cell u_cell (
            .i_clk (i_clk),
            .i_en  (r_busy),
            .i_d   (chain_in[g]),
            .o_q   (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_j    <= '0;
            r_rc   <= 8'h01;
        end else if (r_busy) begin
            r_idx <= r_idx + 6'd1;
            r_j   <= ({1'b0, r_j} == nk - 4'd1) ? 3'd0 : r_j + 3'd1;
            if (!is_key && r_j == 3'd0) begin
                r_rc <= xt(r_rc);
            end
            if (r_idx == total - 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_idx[5:2]][(2'd3 - r_idx[1:0]) * 7'd32 +: 32] <= new_word;
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_key = r_rd;
    assign o_busy   = r_busy;

    `AES_CHECK(a_idx_range, r_busy, r_idx < total, "schedule index past the last word")
    `AES_CHECK(a_phase_range, r_busy, {1'b0, r_j} < nk, "schedule phase out of range")
    `AES_CHECK_NEXT(a_done, r_busy && !i_start && r_idx == total - 6'd1, !r_busy,
        "schedule did not stop after its last word")

endmodule

// File: src/aes_round.sv
module aes_round
    import aes_pkg::*;
(
    input  logic         i_cmd,
    input  logic         i_first,
    input  logic         i_last,
    input  logic [127:0] i_blk,
    input  logic [127:0] i_rk,
    output logic [127:0] o_blk
);

    logic [127:0] sb;
    logic [127:0] sr;
    logic [127:0] mc;
    logic [127:0] isr;
    logic [127:0] isb;
    logic [127:0] xk;
    logic [127:0] imc;
    logic [127:0] enc;
    logic [127:0] dec;

    // Byte 4c+r (row r, column c) sits at bits 127-8(4c+r) down.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[127 - 8 * i -: 8] = sbox(i_blk[127 - 8 * i -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[127 - 8 * (4 * c + r) -: 8]  = sb[127 - 8 * (4 * ((c + r) % 4) + r) -: 8];
                isr[127 - 8 * (4 * c + r) -: 8] =
                    i_blk[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            isb[127 - 8 * i -: 8] = rsbox(isr[127 - 8 * i -: 8]);
        end
        xk = isb ^ i_rk;
        for (int c = 0; c < 4; c++) begin
            mc[127 - 32 * c -: 32]  = mix_col(sr[127 - 32 * c -: 32], 1'b0);
            imc[127 - 32 * c -: 32] = mix_col(xk[127 - 32 * c -: 32], 1'b1);
        end
        enc = (i_last ? sr : mc) ^ i_rk;
        dec = i_last ? xk : imc;
        if (i_first) begin
            o_blk = i_blk ^ i_rk;
        end else if (i_cmd == CMD_DEC) begin
            o_blk = dec;
        end else begin
            o_blk = enc;
        end
    end

endmodule

// File: src/aes_block_cipher_engine.sv
// AES block cipher engine (FIPS-197) for 128, 192 and 256-bit keys.
// Configuration: a write on i_cfg_valid/o_cfg_ready stores a register (index 0 is
// the key size, 1 to 4 are the key bytes); o_cfg_ready is always high. Every write
// to a defined register, and every reset, restarts the key expansion, which writes
// one schedule word per cycle through a chain of eight word cells: 44, 52 or 60
// words for 128, 192 or 256-bit keys. Writes to indexes above four are dropped.
// Input: a transaction on i_in_valid/o_in_stall carries a command and one block.
// o_in_stall is high while the key is expanding or a block is in work.
// The round unit does one round per cycle, the last one waiting while the output is
// stalled, with round keys read from a 15-row store with a registered read port.
// One block is in work at a time and the next one is accepted at the earliest in
// the cycle after the result is registered, so the engine does not take a new
// block before it is through with the last one.
// Output: o_out_valid with i_out_stall. While a finished result is stalled in the
// output register, the next block may already be accepted and run; it then waits
// in its last round until the output register is free.
// Reset (synchronous, active low) clears the key registers to zero and runs the
// key expansion on that all-zero 128-bit key before the first block is accepted.
`include "aes_block_cipher_engine_macros.svh"

module aes_block_cipher_engine
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_block_high,
    output logic [63:0] o_out_block_low
);

    logic [1:0]   r_key_size;
    logic [63:0]  r_key [4];

    t_core_state  r_state;
    t_core_state  n_state;
    logic [3:0]   r_step;
    logic [3:0]   n_step;
    logic         r_cmd;
    logic         n_cmd;
    logic [127:0] r_blk;
    logic [127:0] n_blk;
    logic         r_out_valid;
    logic         n_out_valid;
    logic [127:0] r_out_blk;
    logic [127:0] n_out_blk;

    logic         cfg_wr;
    logic         ks_start;
    logic         ks_busy;
    logic [3:0]   nr;
    logic [3:0]   rd_addr;
    logic [127:0] rk;
    logic [127:0] round_out;
    logic         accept;
    logic         at_last;
    logic         advance;
    logic         finish;

    function automatic logic [3:0] key_row(input logic cmd, input logic [3:0] k,
                                           input logic [3:0] rounds);
        return (cmd == CMD_DEC) ? rounds - k : k;
    endfunction

    // Configuration registers. A key size of three is stored as 256 bits.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign ks_start    = cfg_wr && (i_cfg_index <= REG_KEY_24_31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= KS_128;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_KEY_SIZE:  r_key_size <= (i_cfg_data[1:0] == KS_RSVD) ? KS_256
                                                                          : i_cfg_data[1:0];
                REG_KEY_0_7:   r_key[0] <= i_cfg_data;
                REG_KEY_8_15:  r_key[1] <= i_cfg_data;
                REG_KEY_16_23: r_key[2] <= i_cfg_data;
                REG_KEY_24_31: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_key_size)
            KS_128:  nr = 4'd10;
            KS_192:  nr = 4'd12;
            default: nr = 4'd14;
        endcase
    end

    aes_key_sched u_key_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ks_start),
        .i_key_size (r_key_size),
        .i_key      ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rk),
        .o_busy     (ks_busy)
    );

    aes_round u_round (
        .i_cmd   (r_cmd),
        .i_first (r_step == 4'd0),
        .i_last  (at_last),
        .i_blk   (r_blk),
        .i_rk    (rk),
        .o_blk   (round_out)
    );

    // Step k uses round key k when encrypting and Nr-k when decrypting. The
    // store read for a step is issued in the cycle before it.
    assign o_in_stall  = (r_state != CORE_IDLE) || ks_busy;
    assign accept      = i_in_valid && !o_in_stall;
    assign at_last     = r_step >= nr;
    assign advance     = !at_last || !r_out_valid || !i_out_stall;
    assign finish      = (r_state == CORE_RUN) && at_last && advance;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cmd       = r_cmd;
        n_blk       = r_blk;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_blk   = r_out_blk;
        rd_addr     = key_row(i_command, 4'd0, nr);
        unique case (r_state)
            CORE_IDLE: begin
                if (accept) begin
                    n_state = CORE_RUN;
                    n_step  = 4'd0;
                    n_cmd   = i_command;
                    n_blk   = {i_block_high, i_block_low};
                end
            end
            CORE_RUN: begin
                if (advance && !at_last) begin
                    rd_addr = key_row(r_cmd, r_step + 4'd1, nr);
                end else begin
                    rd_addr = key_row(r_cmd, r_step, nr);
                end
                if (advance) begin
                    n_blk = round_out;
                    if (at_last) begin
                        n_out_blk   = round_out;
                        n_out_valid = 1'b1;
                        n_state     = CORE_IDLE;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            default: n_state = CORE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CORE_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_blk     <= n_blk;
        r_out_blk <= n_out_blk;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_block_high = r_out_blk[127:64];
    assign o_out_block_low  = r_out_blk[63:0];

    `AES_CHECK_NEXT(a_accept_start, accept, r_state == CORE_RUN && r_step == 4'd0,
        "accepted block did not start at step zero")
    `AES_CHECK_NEXT(a_finish_valid, finish, o_out_valid,
        "finished block did not reach the output register")
    `AES_CHECK(a_no_overwrite, r_state == CORE_RUN && at_last && r_out_valid && i_out_stall,
        !finish, "stalled result would be overwritten")

endmodule

// File: bench/tb_top.sv
module tb_top
    import aes_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_BLOCKS = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_out_block_high;
    logic [63:0] o_out_block_low;

    aes_block_cipher_engine dut (.*);

    // The clock runs with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Predictor state: byte tables, the configuration copy and the key schedule.
    logic [7:0]  sbox_fwd [256];
    logic [7:0]  sbox_inv [256];
    logic [1:0]  key_len_sel;
    logic [63:0] key_reg [4];
    logic [31:0] sched [60];

    logic [127:0] cipher_queue [$];
    int           mismatches;
    int           cycle_count;
    bit           quiet;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    // The S-box is built from the multiplicative inverse and the affine map.
    function automatic void build_sboxes();
        logic [7:0] inv;
        logic [7:0] res;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            if (x != 0) begin
                inv = 8'h01;
                for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
            end
            res = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_fwd[x]   = res;
            sbox_inv[res] = x[7:0];
        end
    endfunction

    function automatic int round_count();
        return (key_len_sel == KS_128) ? 10 : ((key_len_sel == KS_192) ? 12 : 14);
    endfunction

    function automatic logic [31:0] sub_four(input logic [31:0] w);
        return {sbox_fwd[w[31:24]], sbox_fwd[w[23:16]], sbox_fwd[w[15:8]],
                sbox_fwd[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int         nk;
        int         total;
        logic [7:0] rcon;
        logic [31:0] t;
        nk    = round_count() - 6;
        total = 4 * (round_count() + 1);
        rcon  = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = nk; i < total; i++) begin
            t = sched[i - 1];
            if (i % nk == 0) begin
                t = sub_four({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_mul(rcon, 8'h02);
            end else if (nk == 8 && i % 8 == 4) begin
                t = sub_four(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
    endfunction

    // State byte i sits at bits 127-8i; column c is the 32-bit word c.
    function automatic logic [127:0] add_round_key(input logic [127:0] v, input int rnd);
        for (int c = 0; c < 4; c++) v[127 - 32 * c -: 32] ^= sched[4 * rnd + c];
        return v;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] v, input bit inv);
        for (int i = 0; i < 16; i++)
            v[127 - 8 * i -: 8] = inv ? sbox_inv[v[127 - 8 * i -: 8]]
                                      : sbox_fwd[v[127 - 8 * i -: 8]];
        return v;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] v, input bit inv);
        logic [127:0] t;
        int           src;
        t = v;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = 4 * ((c + r) % 4) + r;
                if (inv) t[127 - 8 * src -: 8] = v[127 - 8 * (4 * c + r) -: 8];
                else     t[127 - 8 * (4 * c + r) -: 8] = v[127 - 8 * src -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] v, input bit inv);
        logic [7:0]   coef [4];
        logic [7:0]   col [4];
        logic [7:0]   acc;
        logic [127:0] t;
        if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        t = v;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = v[127 - 8 * (4 * c + k) -: 8];
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], coef[(k - r + 4) % 4]);
                t[127 - 8 * (4 * c + r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(input logic cmd, input logic [127:0] v);
        int nr;
        nr = round_count();
        if (cmd == CMD_ENC) begin
            v = add_round_key(v, 0);
            for (int rnd = 1; rnd < nr; rnd++)
                v = add_round_key(mix_columns(shift_rows(sub_bytes(v, 0), 0), 0), rnd);
            v = add_round_key(shift_rows(sub_bytes(v, 0), 0), nr);
        end else begin
            v = add_round_key(v, nr);
            for (int rnd = nr - 1; rnd >= 1; rnd--)
                v = mix_columns(add_round_key(sub_bytes(shift_rows(v, 1), 1), rnd), 1);
            v = add_round_key(sub_bytes(shift_rows(v, 1), 1), 0);
        end
        return v;
    endfunction

    function automatic void note_reg_write(input logic [2:0] idx, input logic [63:0] data);
        if (idx == REG_KEY_SIZE) begin
            key_len_sel = (data[1:0] == KS_RSVD) ? KS_256 : data[1:0];
        end else if (idx <= REG_KEY_24_31) begin
            key_reg[idx - 1] = data;
        end else begin
            return;
        end
        expand_schedule();
    endfunction

    // The cycle counter bounds the run in case the engine hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls in about a quarter of the cycles unless a quiet
    // stretch is running.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 24);
        end
    end

    // Output checker: each transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h", o_out_block_high, o_out_block_low);
            end else begin
                want = cipher_queue.pop_front();
                if (want[127:64] !== o_out_block_high || want[63:0] !== o_out_block_low) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("block mismatch: expected %h %h, got %h %h",
                                 want[127:64], want[63:0], o_out_block_high, o_out_block_low);
                end
            end
        end
    end

    // Waits until every expected block has come out and the engine has settled.
    task automatic drain();
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The caller drops i_cfg_valid after the last write of a group.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        note_reg_write(idx, data);
    endtask

    // Offers one block, with an optional idle gap before it, and records the
    // expected result once the transaction is accepted.
    task automatic send_block(input logic cmd, input logic [127:0] blk, input bit known,
                              input logic [127:0] want);
        while (!quiet && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_block_high <= blk[127:64];
        i_block_low  <= blk[63:0];
        do @(posedge i_clk); while (o_in_stall);
        cipher_queue.push_back(known ? want : cipher_block(cmd, blk));
    endtask

    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [63:0]  data;
        logic         cmd;
        logic [127:0] blk;
        bit           known;
        logic [127:0] want;
    } t_stim_row;

    t_stim_row stim_rows [$];

    function automatic void cfg_row(input logic [2:0] idx, input logic [63:0] data);
        stim_rows.push_back('{1'b1, idx, data, CMD_ENC, 128'h0, 1'b0, 128'h0});
    endfunction

    function automatic void blk_row(input logic cmd, input logic [127:0] blk,
                                    input bit known, input logic [127:0] want);
        stim_rows.push_back('{1'b0, REG_KEY_SIZE, 64'h0, cmd, blk, known, want});
    endfunction

    initial begin
        localparam logic [127:0] PLAIN   = 128'h00112233445566778899aabbccddeeff;
        localparam logic [127:0] CT_128  = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
        localparam logic [127:0] CT_192  = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
        localparam logic [127:0] CT_256  = 128'h8ea2b7ca516745bfeafc49904b496089;
        localparam logic [127:0] ALL_ONE = {128{1'b1}};
        bit prev_cfg;
        logic [2:0] idx;

        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_command    = CMD_ENC;
        i_block_high = '0;
        i_block_low  = '0;
        i_out_stall  = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        quiet        = 1'b0;

        build_sboxes();
        key_len_sel = KS_128;
        key_reg     = '{default: 64'h0};
        expand_schedule();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The reset key is all zero; the known-answer vectors
        // use the sequential keys of the standard.
        blk_row(CMD_ENC, 128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        blk_row(CMD_ENC, ALL_ONE, 1'b0, 128'h0);
        blk_row(CMD_DEC, 128'h0, 1'b0, 128'h0);
        cfg_row(REG_KEY_0_7, 64'h0001020304050607);
        cfg_row(REG_KEY_8_15, 64'h08090a0b0c0d0e0f);
        blk_row(CMD_ENC, PLAIN, 1'b1, CT_128);
        blk_row(CMD_DEC, CT_128, 1'b1, PLAIN);
        cfg_row(REG_KEY_16_23, 64'h1011121314151617);
        cfg_row(REG_KEY_SIZE, 64'(KS_192));
        blk_row(CMD_ENC, PLAIN, 1'b1, CT_192);
        blk_row(CMD_DEC, CT_192, 1'b1, PLAIN);
        cfg_row(REG_KEY_24_31, 64'h18191a1b1c1d1e1f);
        cfg_row(REG_KEY_SIZE, 64'(KS_256));
        blk_row(CMD_ENC, PLAIN, 1'b1, CT_256);
        blk_row(CMD_DEC, CT_256, 1'b1, PLAIN);
        // The reserved key size behaves as a 256-bit key.
        cfg_row(REG_KEY_SIZE, 64'(KS_RSVD));
        blk_row(CMD_ENC, PLAIN, 1'b1, CT_256);
        // Writes beyond the last register change nothing.
        cfg_row(3'd5, 64'hffffffffffffffff);
        cfg_row(3'd7, 64'hffffffffffffffff);
        blk_row(CMD_DEC, CT_256, 1'b1, PLAIN);
        // Back to 128 bits: the upper key bytes are still set but are ignored.
        cfg_row(REG_KEY_SIZE, 64'(KS_128));
        blk_row(CMD_ENC, PLAIN, 1'b1, CT_128);
        blk_row(CMD_DEC, ALL_ONE, 1'b0, 128'h0);
        // All-ones key at the largest size.
        for (int r = 1; r <= 4; r++) cfg_row(r[2:0], 64'hffffffffffffffff);
        cfg_row(REG_KEY_SIZE, 64'(KS_256));
        blk_row(CMD_ENC, 128'h0, 1'b0, 128'h0);
        blk_row(CMD_DEC, ALL_ONE, 1'b0, 128'h0);

        prev_cfg = 1'b0;
        foreach (stim_rows[n]) begin
            if (stim_rows[n].is_cfg) begin
                if (!prev_cfg) begin
                    i_in_valid <= 1'b0;
                    drain();
                end
                write_reg(stim_rows[n].idx, stim_rows[n].data);
            end else begin
                if (prev_cfg) begin
                    i_cfg_valid <= 1'b0;
                end
                send_block(stim_rows[n].cmd, stim_rows[n].blk, stim_rows[n].known,
                           stim_rows[n].want);
            end
            prev_cfg = stim_rows[n].is_cfg;
        end
        i_cfg_valid <= 1'b0;

        // Random phases: a fresh key setting, then a burst of random blocks.
        // Two phases in the middle run without any idling on either side.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            drain();
            quiet = (ph == 5 || ph == 6);
            for (int r = 1; r <= 4; r++) write_reg(r[2:0], {$urandom, $urandom});
            write_reg(REG_KEY_SIZE, {$urandom, $urandom});
            if ($urandom_range(3) == 0) begin
                idx = 3'($urandom_range(7, 5));
                write_reg(idx, {$urandom, $urandom});
            end
            i_cfg_valid <= 1'b0;
            for (int b = 0; b < PHASE_BLOCKS; b++)
                send_block(1'($urandom_range(1)), {$urandom, $urandom, $urandom, $urandom},
                           1'b0, 128'h0);
        end
        i_in_valid <= 1'b0;
        quiet = 1'b0;
        drain();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
